/* rtl/m3s_pkg.sv */
// Shared types and constants for the 3x3 transform and Cramer solve unit.
// No dependencies.
package m3s_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ENTRY_WIDTH_DEF = 20;
  localparam int FRAC_BITS       = 16;
  localparam logic [31:0] ONE_VAL = 32'h0001_0000;

  // transaction opcodes
  typedef enum logic [1:0] {
    OP_MUL    = 2'd0,
    OP_TMUL   = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_TSOLVE = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  // per-stage control that travels with the data
  typedef struct packed {
    logic valid;
    logic sing;
  } ctl_t;

endpackage

/* rtl/matrix3_transform_and_solve_unit.sv */
// Top level of the 3x3 transform and Cramer solve unit: matrix registers,
// front pipeline, divider pipeline, rounding and output register.
// Depends on m3s_pkg, m3s_front, m3s_div.
//
// Usage:
//   Configuration: write the three matrix rows (index 0..2) over cfg_valid /
//   cfg_ready / cfg_index / cfg_data while no transaction is in flight.
//   cfg_ready is always high; index 3 is ignored. Reset loads the identity.
//   Input: one point and opcode per transaction on in_valid / in_ready.
//   Output: one result per transaction on out_valid / out_ready, in order.
//   Stages: five front stages, COORD_WIDTH + 1 divider stages and one
//   rounding/output stage lie between accept and out_valid.
//   Throughput: one transaction per cycle while out_ready stays high; the
//   divider issues one quotient bit per stage for all three lanes at once.
//   Stalls: when out_ready is low the output register holds; every stage
//   that holds data stalls only if the stage after it is full, so bubbles
//   fill up and in_ready drops once the whole pipeline is full.
//   Reset clears all valid bits; no transaction is lost or repeated.
module matrix3_transform_and_solve_unit import m3s_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_singular,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [3*ENTRY_WIDTH-1:0]      cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = ENTRY_WIDTH;
  localparam int XW = 2*EW + 1;
  localparam int DW = 3*EW + 3;
  localparam int NW = XW + CW + 2 + FRAC_BITS;
  localparam logic [EW-1:0] ONE_E = ONE_VAL[EW-1:0];
  localparam logic [CW:0]   LIM   = (CW+1)'(1) << (CW-1);

  // matrix rows
  logic [3*EW-1:0] row_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        row_r[r] <= (3*EW)'(ONE_E) << (r*EW);
      end
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROW0: row_r[0] <= cfg_data;
        REG_ROW1: row_r[1] <= cfg_data;
        REG_ROW2: row_r[2] <= cfg_data;
        REG_NONE: ;
        default:  ;
      endcase
    end
  end

  // front pipeline
  ctl_t          f_ctl;
  logic [NW-1:0] f_mag [3];
  logic          f_neg [3];
  logic [DW-1:0] f_d;
  logic [CW-1:0] f_pt [3];
  logic          div_en_in;

  m3s_front #(.CW(CW), .EW(EW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op_i    (in_opcode),
    .px_i    (in_x),
    .py_i    (in_y),
    .pz_i    (in_z),
    .row_i   (row_r),
    .en_out  (div_en_in),
    .ctl_o   (f_ctl),
    .mag_o   (f_mag),
    .neg_o   (f_neg),
    .d_o     (f_d),
    .pt_o    (f_pt)
  );

  // divider pipeline
  ctl_t          q_ctl;
  logic [DW-1:0] q_rem [3];
  logic [CW-1:0] q_q [3];
  logic          q_ovf [3];
  logic          q_neg [3];
  logic [DW-1:0] q_d;
  logic [CW-1:0] q_pt [3];
  logic          out_en;

  m3s_div #(.CW(CW), .EW(EW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en_in (div_en_in),
    .en_out(out_en),
    .ctl_i (f_ctl),
    .mag_i (f_mag),
    .neg_i (f_neg),
    .d_i   (f_d),
    .pt_i  (f_pt),
    .ctl_o (q_ctl),
    .rem_o (q_rem),
    .q_o   (q_q),
    .ovf_o (q_ovf),
    .neg_o (q_neg),
    .d_o   (q_d),
    .pt_o  (q_pt)
  );

  // round half away from zero, saturate, pick pass-through
  logic          out_valid_r;
  logic [CW-1:0] res_r [3];
  logic          sing_r, sat_r;
  logic [CW:0]   qr [3];
  logic [CW-1:0] res_nxt [3];
  logic          sat_l [3];

  assign out_en = !out_valid_r || out_ready;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qr[l] = {1'b0, q_q[l]} + (CW+1)'({q_rem[l], 1'b0} >= {1'b0, q_d});
      sat_l[l] = 1'b0;
      if (q_ctl.sing) begin
        res_nxt[l] = q_pt[l];
      end else if (!q_neg[l]) begin
        if (q_ovf[l] || qr[l] > LIM - (CW+1)'(1)) begin
          sat_l[l]   = 1'b1;
          res_nxt[l] = CW'(LIM - (CW+1)'(1));
        end else begin
          res_nxt[l] = CW'(qr[l]);
        end
      end else begin
        if (q_ovf[l] || qr[l] > LIM) begin
          sat_l[l]   = 1'b1;
          res_nxt[l] = CW'(LIM);
        end else begin
          res_nxt[l] = CW'(~qr[l] + (CW+1)'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_en) out_valid_r <= q_ctl.valid;
  end

  always_ff @(posedge clk) begin
    if (out_en && q_ctl.valid) begin
      res_r  <= res_nxt;
      sing_r <= q_ctl.sing;
      sat_r  <= sat_l[0] | sat_l[1] | sat_l[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];
  assign out_z         = res_r[2];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

endmodule

/* rtl/m3s_front.sv */
// Front pipeline: matrix select, cross products, dot products, determinant,
// sign and magnitude of numerators. Depends on m3s_pkg.
module m3s_front import m3s_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int EW = ENTRY_WIDTH_DEF,
  localparam int XW = 2*EW + 1,
  localparam int DW = 3*EW + 3,
  localparam int NW = XW + CW + 2 + FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  input  logic signed [CW-1:0] pz_i,
  input  logic [3*EW-1:0]      row_i [3],
  input  logic                 en_out,
  output ctl_t                 ctl_o,
  output logic [NW-1:0]        mag_o [3],
  output logic                 neg_o [3],
  output logic [DW-1:0]        d_o,
  output logic [CW-1:0]        pt_o [3]
);

  localparam int KL = EW + 1;

  logic en1, en2, en3, en4, en5;
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;

  // stall chain: a stage advances when empty or when the next one advances
  assign en5      = !vld5_r || en_out;
  assign en4      = !vld4_r || en5;
  assign en3      = !vld3_r || en4;
  assign en2      = !vld2_r || en3;
  assign en1      = !vld1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
      if (en5) vld5_r <= vld4_r;
    end
  end

  // stage 1: pick rows or columns, capture the point
  logic              sol1_r;
  logic signed [CW-1:0] p1_r [3];
  logic signed [EW-1:0] m1_r [3][3];
  logic signed [EW-1:0] m1_nxt [3][3];
  logic              trn;

  always_comb begin
    trn = (op_t'(op_i) == OP_TMUL) || (op_t'(op_i) == OP_SOLVE);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (trn) m1_nxt[r][c] = row_i[c][r*EW +: EW];
        else     m1_nxt[r][c] = row_i[r][c*EW +: EW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      sol1_r <= op_i[1];
      p1_r[0] <= px_i;
      p1_r[1] <= py_i;
      p1_r[2] <= pz_i;
      m1_r    <= m1_nxt;
    end
  end

  // stage 2: cross products for solves, plain rows for multiplies
  logic              sol2_r;
  logic signed [CW-1:0] p2_r [3];
  logic signed [EW-1:0] v0_2_r [3];
  logic signed [XW-1:0] k2_r [3][3];
  logic signed [XW-1:0] k2_nxt [3][3];
  logic signed [2*EW-1:0] pa, pb;
  int a, b, c1, c2;

  always_comb begin
    pa = '0;
    pb = '0;
    a = 0; b = 0; c1 = 0; c2 = 0;
    for (int r = 0; r < 3; r++) begin
      a = (r == 2) ? 0 : r + 1;
      b = (r == 0) ? 2 : r - 1;
      for (int c = 0; c < 3; c++) begin
        c1 = (c == 2) ? 0 : c + 1;
        c2 = (c == 0) ? 2 : c - 1;
        pa = m1_r[a][c1] * m1_r[b][c2];
        pb = m1_r[a][c2] * m1_r[b][c1];
        if (sol1_r) k2_nxt[r][c] = XW'(pa) - XW'(pb);
        else        k2_nxt[r][c] = XW'(m1_r[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && vld1_r) begin
      sol2_r <= sol1_r;
      p2_r   <= p1_r;
      v0_2_r <= m1_r[0];
      k2_r   <= k2_nxt;
    end
  end

  // stage 3: all products; split each coefficient into a signed high part
  // and an unsigned low part so each multiplier stays narrow
  logic              sol3_r;
  logic signed [CW-1:0]      p3_r [3];
  logic signed [XW-KL+CW-1:0] ph3_r [3][3];
  logic signed [KL+CW:0]     pl3_r [3][3];
  logic signed [EW+XW-1:0]   dp3_r [3];

  always_ff @(posedge clk) begin
    if (en3 && vld2_r) begin
      sol3_r <= sol2_r;
      p3_r   <= p2_r;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ph3_r[r][c] <= $signed(k2_r[r][c][XW-1:KL]) * p2_r[c];
          pl3_r[r][c] <= $signed({1'b0, k2_r[r][c][KL-1:0]}) * p2_r[c];
        end
        dp3_r[r] <= v0_2_r[r] * k2_r[0][r];
      end
    end
  end

  // stage 4: sums, scale solve numerators
  logic              sol4_r;
  logic signed [CW-1:0] p4_r [3];
  logic signed [NW-1:0] n4_r [3];
  logic signed [DW-1:0] det4_r;
  logic signed [XW+CW+1:0] s4 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s4[r] = '0;
      for (int c = 0; c < 3; c++) begin
        s4[r] = s4[r] + ((XW+CW+2)'(ph3_r[r][c]) <<< KL) + (XW+CW+2)'(pl3_r[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && vld3_r) begin
      sol4_r <= sol3_r;
      p4_r   <= p3_r;
      for (int r = 0; r < 3; r++) begin
        if (sol3_r) n4_r[r] <= NW'(s4[r]) <<< FRAC_BITS;
        else        n4_r[r] <= NW'(s4[r]);
      end
      det4_r <= DW'(dp3_r[0]) + DW'(dp3_r[1]) + DW'(dp3_r[2]);
    end
  end

  // stage 5: singular check, sign and magnitude
  logic sing5_r;
  logic dneg;

  assign dneg = sol4_r && det4_r[DW-1];

  always_ff @(posedge clk) begin
    if (en5 && vld4_r) begin
      sing5_r <= sol4_r && (det4_r == '0);
      if (sol4_r) d_o <= det4_r[DW-1] ? DW'(-det4_r) : DW'(det4_r);
      else        d_o <= DW'(ONE_VAL);
      for (int r = 0; r < 3; r++) begin
        neg_o[r] <= n4_r[r][NW-1] ^ dneg;
        mag_o[r] <= n4_r[r][NW-1] ? NW'(-n4_r[r]) : NW'(n4_r[r]);
        pt_o[r]  <= p4_r[r];
      end
    end
  end

  assign ctl_o.valid = vld5_r;
  assign ctl_o.sing  = sing5_r;

endmodule

/* rtl/m3s_div.sv */
// Pipelined restoring divider, one quotient bit per stage, three lanes that
// share one divisor. Depends on m3s_pkg.
module m3s_div import m3s_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int EW = ENTRY_WIDTH_DEF,
  localparam int XW = 2*EW + 1,
  localparam int DW = 3*EW + 3,
  localparam int NW = XW + CW + 2 + FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          en_in,
  input  logic          en_out,
  input  ctl_t          ctl_i,
  input  logic [NW-1:0] mag_i [3],
  input  logic          neg_i [3],
  input  logic [DW-1:0] d_i,
  input  logic [CW-1:0] pt_i [3],
  output ctl_t          ctl_o,
  output logic [DW-1:0] rem_o [3],
  output logic [CW-1:0] q_o [3],
  output logic          ovf_o [3],
  output logic          neg_o [3],
  output logic [DW-1:0] d_o,
  output logic [CW-1:0] pt_o [3]
);

  logic          en  [CW+2];
  ctl_t          ctl_r [CW+1];
  logic [DW-1:0] rem_r [CW+1][3];
  logic [CW-1:0] q_r   [CW+1][3];
  logic [CW-1:0] lo_r  [CW+1][3];
  logic          ovf_r [CW+1][3];
  logic          neg_r [CW+1][3];
  logic [DW-1:0] d_r   [CW+1];
  logic [CW-1:0] pt_r  [CW+1][3];

  assign en[CW+1] = en_out;
  assign en_in    = en[0];

  // stage 0: overflow precheck and initial remainder
  assign en[0] = !ctl_r[0].valid || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_r[0].valid <= 1'b0;
    else if (en[0]) ctl_r[0].valid <= ctl_i.valid;
  end

  always_ff @(posedge clk) begin
    if (en[0] && ctl_i.valid) begin
      ctl_r[0].sing <= ctl_i.sing;
      d_r[0]        <= d_i;
      for (int l = 0; l < 3; l++) begin
        ovf_r[0][l] <= (mag_i[l] >> CW) >= NW'(d_i);
        rem_r[0][l] <= DW'(mag_i[l] >> CW);
        lo_r[0][l]  <= mag_i[l][CW-1:0];
        q_r[0][l]   <= '0;
        neg_r[0][l] <= neg_i[l];
        pt_r[0][l]  <= pt_i[l];
      end
    end
  end

  // stages 1..CW: one quotient bit each
  for (genvar s = 1; s <= CW; s++) begin : g_step
    logic [DW:0] t  [3];
    logic        ge [3];

    assign en[s] = !ctl_r[s].valid || en[s+1];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]  = {rem_r[s-1][l], lo_r[s-1][l][CW-1]};
        ge[l] = t[l] >= {1'b0, d_r[s-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) ctl_r[s].valid <= 1'b0;
      else if (en[s]) ctl_r[s].valid <= ctl_r[s-1].valid;
    end

    always_ff @(posedge clk) begin
      if (en[s] && ctl_r[s-1].valid) begin
        ctl_r[s].sing <= ctl_r[s-1].sing;
        d_r[s]        <= d_r[s-1];
        for (int l = 0; l < 3; l++) begin
          rem_r[s][l] <= ge[l] ? DW'(t[l] - {1'b0, d_r[s-1]}) : DW'(t[l]);
          q_r[s][l]   <= {q_r[s-1][l][CW-2:0], ge[l]};
          lo_r[s][l]  <= lo_r[s-1][l] << 1;
          ovf_r[s][l] <= ovf_r[s-1][l];
          neg_r[s][l] <= neg_r[s-1][l];
          pt_r[s][l]  <= pt_r[s-1][l];
        end
      end
    end
  end

  assign ctl_o = ctl_r[CW];
  assign d_o   = d_r[CW];
  assign rem_o = rem_r[CW];
  assign q_o   = q_r[CW];
  assign ovf_o = ovf_r[CW];
  assign neg_o = neg_r[CW];
  assign pt_o  = pt_r[CW];

endmodule
